### rtl/lph_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lph_pkg;

    localparam int CAPACITY   = 1024;
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 11;
    localparam int ADDR_BITS  = 3;

    localparam int IN_TDATA_BITS  = KEY_BITS + VALUE_BITS;
    localparam int OUT_FIELD_BITS = 1 + VALUE_BITS + 1 + COUNT_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

    localparam logic [COUNT_BITS-1:0] LIMIT_RESET = COUNT_BITS'(768);

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [ADDR_BITS-1:0] REG_LIVE_LIMIT = ADDR_BITS'(0);

    typedef struct packed {
        logic                  used;
        logic                  live;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } slot_t;

    localparam int SLOT_BITS = $bits(slot_t);

endpackage

`default_nettype wire

### rtl/lph_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/linear_probe_hash_map_unit.sv
// Key/value table, open addressing with linear probing, one item at a time.
// Input beats (s_*): kind in s_tuser (0 insert/replace, 1 lookup, 2 remove,
// 3 acts as lookup), key and value in s_tdata. Each input beat yields exactly
// one output beat (m_*) with found, old_value, status and live_count.
// The home slot is the low key bits; a probe walks forward and wraps, ending
// at a never-used slot, a live match, or after CAPACITY probes.
// Each probed slot takes a RAM read (S_PROBE) and a check (S_CHECK), as the
// slot RAM has a registered read port; then S_UPDATE writes the slot and
// S_DONE loads the output register. The unit goes back to idle to take the
// next beat, so it takes no new item before the last one has left S_DONE.
// s_tready is high only while the unit is idle; the next item is taken while
// a finished result still sits in the output register.
// If the receiver stalls, the result holds in m_tdata with m_tvalid high; a
// second result waits inside until the register frees.
// After rst_n the unit clears every slot of the slot RAM with s_tready low;
// the APB port (live_limit at address 0, reset 768) works throughout.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_map_unit
    import lph_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // s_tdata: key [31:0], value [63:32]
    input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,
    // s_tuser: kind [1:0]
    input  wire logic [1:0]                s_tuser,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // m_tdata: found [0], old_value [32:1], status [33], live_count [44:34], zero pad
    output logic      [OUT_TDATA_BITS-1:0] m_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ADDR_BITS-1:0]      paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_CHECK,
        S_UPDATE,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [IDX_BITS-1:0]      idx_reg, idx_next;
    logic [IDX_BITS-1:0]      probe_n_reg, probe_n_next;
    logic [1:0]               kind_reg, kind_next;
    logic [KEY_BITS-1:0]      key_reg, key_next;
    logic [VALUE_BITS-1:0]    value_reg, value_next;
    logic                     free_valid_reg, free_valid_next;
    logic [IDX_BITS-1:0]      free_idx_reg, free_idx_next;
    logic                     hit_reg, hit_next;
    logic [VALUE_BITS-1:0]    old_reg, old_next;
    logic                     status_reg, status_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [COUNT_BITS-1:0]    limit_reg, limit_next;
    logic [OUT_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    logic                  ram_we;
    logic [IDX_BITS-1:0]   ram_waddr;
    slot_t                 ram_wdata;
    logic                  ram_re;
    logic [SLOT_BITS-1:0]  ram_rdata;
    slot_t                 rd_slot;
    logic                  cfg_write;

    lph_ram #(
        .WIDTH(SLOT_BITS),
        .DEPTH(CAPACITY)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    assign rd_slot   = slot_t'(ram_rdata);
    assign ram_re    = (state_reg == S_PROBE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[ADDR_BITS-1:2] == REG_LIVE_LIMIT[ADDR_BITS-1:2])
                       ? 32'(limit_reg) : 32'd0;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tdata   = m_tdata_reg;
    assign m_tvalid  = m_tvalid_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        probe_n_next    = probe_n_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        free_valid_next = free_valid_reg;
        free_idx_next   = free_idx_reg;
        hit_next        = hit_reg;
        old_next        = old_reg;
        status_next     = status_reg;
        count_next      = count_reg;
        limit_next      = limit_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = '0;

        if (cfg_write && (paddr[ADDR_BITS-1:2] == REG_LIVE_LIMIT[ADDR_BITS-1:2]))
        begin
            limit_next = pwdata[COUNT_BITS-1:0];
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (&idx_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next       = s_tuser;
                    key_next        = s_tdata[KEY_BITS-1:0];
                    value_next      = s_tdata[KEY_BITS +: VALUE_BITS];
                    idx_next        = s_tdata[IDX_BITS-1:0];
                    probe_n_next    = '0;
                    free_valid_next = 1'b0;
                    hit_next        = 1'b0;
                    old_next        = '0;
                    status_next     = 1'b0;
                    state_next      = S_PROBE;
                end
            end
            S_PROBE:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!rd_slot.used)
                begin
                    if (!free_valid_reg)
                    begin
                        free_valid_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    state_next = S_UPDATE;
                end
                else if (rd_slot.live && (rd_slot.key == key_reg))
                begin
                    hit_next   = 1'b1;
                    old_next   = rd_slot.value;
                    state_next = S_UPDATE;
                end
                else
                begin
                    if (!rd_slot.live && !free_valid_reg)
                    begin
                        free_valid_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (&probe_n_reg)
                    begin
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        idx_next     = idx_reg + 1'b1;
                        probe_n_next = probe_n_reg + 1'b1;
                        state_next   = S_PROBE;
                    end
                end
            end
            S_UPDATE:
            begin
                // on a hit idx_reg still points at the matching slot
                if (kind_reg == KIND_INSERT)
                begin
                    if (hit_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = '{used: 1'b1, live: 1'b1, key: key_reg, value: value_reg};
                    end
                    else if ((count_reg >= limit_reg) || !free_valid_reg)
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = free_idx_reg;
                        ram_wdata  = '{used: 1'b1, live: 1'b1, key: key_reg, value: value_reg};
                        count_next = count_reg + 1'b1;
                    end
                end
                else if ((kind_reg == KIND_REMOVE) && hit_reg)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = '{used: 1'b1, live: 1'b0, key: key_reg, value: old_reg};
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next  = {{OUT_PAD_BITS{1'b0}}, count_reg, status_reg,
                                     old_reg, hit_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            probe_n_reg    <= '0;
            kind_reg       <= KIND_LOOKUP;
            key_reg        <= '0;
            value_reg      <= '0;
            free_valid_reg <= 1'b0;
            free_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            old_reg        <= '0;
            status_reg     <= 1'b0;
            count_reg      <= '0;
            limit_reg      <= LIMIT_RESET;
            m_tdata_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            probe_n_reg    <= probe_n_next;
            kind_reg       <= kind_next;
            key_reg        <= key_next;
            value_reg      <= value_next;
            free_valid_reg <= free_valid_next;
            free_idx_reg   <= free_idx_next;
            hit_reg        <= hit_next;
            old_reg        <= old_next;
            status_reg     <= status_next;
            count_reg      <= count_next;
            limit_reg      <= limit_next;
            m_tdata_reg    <= m_tdata_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(CAPACITY))
        else $error("live count above capacity");

    a_no_write_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_UPDATE))
        else $error("slot RAM written outside clear or update");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside done state");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_UPDATE) |=> $stable(count_reg))
        else $error("live count changed outside update");
`endif

endmodule

`default_nettype wire

### tb/linear_probe_hash_map_unit_tb.sv
`timescale 1ns / 1ps

module linear_probe_hash_map_unit_tb;
    import lph_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;  // decodes as a lookup
    localparam logic [ADDR_BITS-1:0] LIMIT_ADDR = ADDR_BITS'(4 * REG_LIVE_LIMIT);
    localparam int DIR_ROWS = 25;
    localparam int PHASES = 6;
    localparam int PHASE_OPS = 40;

    typedef struct packed {
        bit                    found;
        logic [VALUE_BITS-1:0] old_value;
        bit                    status;
        logic [COUNT_BITS-1:0] live_count;
    } map_result_t;

    typedef struct packed {
        bit                    cfg;
        logic [COUNT_BITS-1:0] limit;
        logic [1:0]            op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] val;
        bit                    typed;
        map_result_t           res;
    } dir_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
    logic [1:0]                s_tuser = KIND_INSERT;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_BITS-1:0]      paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;

    linear_probe_hash_map_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // shadow table
    bit                    tbl_used [CAPACITY];
    bit                    tbl_live [CAPACITY];
    logic [KEY_BITS-1:0]   tbl_key [CAPACITY];
    logic [VALUE_BITS-1:0] tbl_val [CAPACITY];
    logic [COUNT_BITS-1:0] tbl_count = '0;
    logic [COUNT_BITS-1:0] tbl_limit = LIMIT_RESET;

    map_result_t pending_results [$];
    map_result_t oldest_result;
    logic [KEY_BITS-1:0] key_pool [$];

    int gap_pct = 35;
    int stall_pct = 35;
    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int limit_writes = 0;

    logic [COUNT_BITS-1:0] phase_limit [PHASES] = '{
        11'd1024, 11'd48, 11'd2047, 11'd1, 11'd300, 11'd0
    };

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{1'b0, 11'd0, KIND_LOOKUP, 32'h0, 32'h0, 1'b1, '{1'b0, 32'h0, 1'b0, 11'd0}},
        '{1'b0, 11'd0, KIND_REMOVE, 32'hFFFFFFFF, 32'h0, 1'b1,
          '{1'b0, 32'h0, 1'b0, 11'd0}},
        '{1'b0, 11'd0, KIND_INSERT, 32'h0, 32'hFFFFFFFF, 1'b1,
          '{1'b0, 32'h0, 1'b0, 11'd1}},
        '{1'b0, 11'd0, KIND_INSERT, 32'hFFFFFFFF, 32'h0, 1'b1,
          '{1'b0, 32'h0, 1'b0, 11'd2}},
        '{1'b0, 11'd0, KIND_LOOKUP, 32'h0, 32'h0, 1'b1,
          '{1'b1, 32'hFFFFFFFF, 1'b0, 11'd2}},
        '{1'b0, 11'd0, KIND_SPARE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
          '{1'b1, 32'h0, 1'b0, 11'd2}},
        // same home slot as key 0
        '{1'b0, 11'd0, KIND_INSERT, 32'h400, 32'h12345678, 1'b1,
          '{1'b0, 32'h0, 1'b0, 11'd3}},
        '{1'b0, 11'd0, KIND_INSERT, 32'h0, 32'hA5A5A5A5, 1'b1,
          '{1'b1, 32'hFFFFFFFF, 1'b0, 11'd3}},
        '{1'b0, 11'd0, KIND_REMOVE, 32'h0, 32'h0, 1'b1,
          '{1'b1, 32'hA5A5A5A5, 1'b0, 11'd2}},
        // found past a tombstone, replaced rather than duplicated
        '{1'b0, 11'd0, KIND_LOOKUP, 32'h400, 32'h0, 1'b1,
          '{1'b1, 32'h12345678, 1'b0, 11'd2}},
        '{1'b0, 11'd0, KIND_INSERT, 32'h400, 32'h55, 1'b1,
          '{1'b1, 32'h12345678, 1'b0, 11'd2}},
        '{1'b0, 11'd0, KIND_INSERT, 32'h800, 32'h1, 1'b0, '0},
        '{1'b0, 11'd0, KIND_REMOVE, 32'h400, 32'h0, 1'b0, '0},
        '{1'b0, 11'd0, KIND_REMOVE, 32'h400, 32'h0, 1'b1,
          '{1'b0, 32'h0, 1'b0, 11'd2}},
        '{1'b0, 11'd0, KIND_INSERT, 32'hFFFFFC00, 32'h7, 1'b0, '0},
        // chain wraps from the last slot
        '{1'b0, 11'd0, KIND_INSERT, 32'h3FF, 32'h0BADF00D, 1'b0, '0},
        '{1'b0, 11'd0, KIND_LOOKUP, 32'h3FF, 32'h0, 1'b0, '0},
        '{1'b1, 11'd0, KIND_INSERT, 32'h0, 32'h0, 1'b0, '0},
        '{1'b0, 11'd0, KIND_INSERT, 32'h5, 32'h1, 1'b1, '{1'b0, 32'h0, 1'b1, 11'd4}},
        '{1'b0, 11'd0, KIND_INSERT, 32'h3FF, 32'h9, 1'b0, '0},
        '{1'b1, 11'd4, KIND_INSERT, 32'h0, 32'h0, 1'b0, '0},
        '{1'b0, 11'd0, KIND_INSERT, 32'h6, 32'h2, 1'b0, '0},
        '{1'b0, 11'd0, KIND_REMOVE, 32'h800, 32'h0, 1'b0, '0},
        '{1'b0, 11'd0, KIND_INSERT, 32'h6, 32'h3, 1'b0, '0},
        '{1'b1, 11'd1024, KIND_INSERT, 32'h0, 32'h0, 1'b0, '0}
    };

    // live slot of key, or -1; free_slot gets first tombstone or empty slot
    function automatic int chain_walk(input logic [KEY_BITS-1:0] key, output int free_slot);
        int slot;
        slot = int'(key[IDX_BITS-1:0]);
        free_slot = -1;
        for (int n = 0; n < CAPACITY; n++)
        begin
            if (!tbl_used[slot])
            begin
                if (free_slot < 0)
                    free_slot = slot;
                return -1;
            end
            if (tbl_live[slot])
            begin
                if (tbl_key[slot] == key)
                    return slot;
            end
            else if (free_slot < 0)
                free_slot = slot;
            slot = (slot + 1) % CAPACITY;
        end
        return -1;
    endfunction

    function automatic map_result_t table_step(input logic [1:0] op,
                                               input logic [KEY_BITS-1:0] key,
                                               input logic [VALUE_BITS-1:0] val);
        map_result_t r;
        int free_slot;
        int hit;
        r = '0;
        hit = chain_walk(key, free_slot);
        if (hit >= 0)
        begin
            r.found = 1'b1;
            r.old_value = tbl_val[hit];
        end
        if (op == KIND_INSERT)
        begin
            if (hit >= 0)
                tbl_val[hit] = val;
            else if (tbl_count >= tbl_limit || free_slot < 0)
                r.status = 1'b1;
            else
            begin
                tbl_key[free_slot] = key;
                tbl_val[free_slot] = val;
                tbl_used[free_slot] = 1'b1;
                tbl_live[free_slot] = 1'b1;
                tbl_count = tbl_count + 1'b1;
            end
        end
        else if (op == KIND_REMOVE && hit >= 0)
        begin
            tbl_live[hit] = 1'b0;
            if (tbl_count != 0)
                tbl_count = tbl_count - 1'b1;
        end
        r.live_count = tbl_count;
        return r;
    endfunction

    function automatic logic [KEY_BITS-1:0] fresh_key(input int home);
        logic [KEY_BITS-1:0] k;
        int spare;
        do
        begin
            k = $urandom;
            k[IDX_BITS-1:0] = IDX_BITS'(home);
        end
        while (chain_walk(k, spare) >= 0);
        return k;
    endfunction

    task automatic send_op(input logic [1:0] op, input logic [KEY_BITS-1:0] key,
                           input logic [VALUE_BITS-1:0] val, input bit typed,
                           input map_result_t typed_res);
        map_result_t r;
        if ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, key};
        do @(posedge clk); while (!s_tready);
        r = table_step(op, key, val);
        pending_results.push_back(typed ? typed_res : r);
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // write, then read back
    task automatic write_limit(input logic [COUNT_BITS-1:0] lim);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= 32'(lim);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tbl_limit = lim;
        limit_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== 32'(lim))
        begin
            $display("%0t: live_limit readback: expected %0d, got %0d", $time, lim, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat: expected none, got %h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                results_checked++;
                if (m_tdata[0] !== oldest_result.found)
                begin
                    $display("%0t: found: expected %0d, got %0d", $time,
                             oldest_result.found, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[VALUE_BITS:1] !== oldest_result.old_value)
                begin
                    $display("%0t: old_value: expected %h, got %h", $time,
                             oldest_result.old_value, m_tdata[VALUE_BITS:1]);
                    mismatches++;
                end
                if (m_tdata[VALUE_BITS+1] !== oldest_result.status)
                begin
                    $display("%0t: status: expected %0d, got %0d", $time,
                             oldest_result.status, m_tdata[VALUE_BITS+1]);
                    mismatches++;
                end
                if (m_tdata[VALUE_BITS+2 +: COUNT_BITS] !== oldest_result.live_count)
                begin
                    $display("%0t: live_count: expected %0d, got %0d", $time,
                             oldest_result.live_count, m_tdata[VALUE_BITS+2 +: COUNT_BITS]);
                    mismatches++;
                end
                if (m_tdata[OUT_TDATA_BITS-1:OUT_FIELD_BITS] !== '0)
                begin
                    $display("%0t: pad: expected 0, got %h", $time,
                             m_tdata[OUT_TDATA_BITS-1:OUT_FIELD_BITS]);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int roll;
        int base;
        int slot;
        logic [1:0] op;
        logic [KEY_BITS-1:0] key;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].cfg)
                write_limit(dir_rows[i].limit);
            else
                send_op(dir_rows[i].op, dir_rows[i].key, dir_rows[i].val,
                        dir_rows[i].typed, dir_rows[i].res);
        end

        // each phase works a 64-slot window so probe chains stay short
        for (int p = 0; p < PHASES; p++)
        begin
            write_limit(phase_limit[p]);
            gap_pct = (p == 2) ? 0 : 35;
            stall_pct = gap_pct;
            base = p * 160 + $urandom_range(31);
            key_pool.delete();
            for (int n = 0; n < PHASE_OPS; n++)
            begin
                roll = $urandom_range(99);
                op = (roll < 45) ? KIND_INSERT : (roll < 70) ? KIND_LOOKUP :
                     (roll < 95) ? KIND_REMOVE : KIND_SPARE;
                roll = $urandom_range(99);
                if (roll < 65 && key_pool.size() != 0)
                    key = key_pool[$urandom_range(key_pool.size() - 1)];
                else if (roll < 95)
                begin
                    key = $urandom;
                    key[IDX_BITS-1:0] = IDX_BITS'(base + $urandom_range(63));
                    key_pool.push_back(key);
                    if (key_pool.size() > 64)
                        void'(key_pool.pop_front());
                end
                else
                    key = $urandom;
                send_op(op, key, $urandom, 1'b0, '0);
                if (n % 20 == 19)
                    drain_results();
            end
        end

        // fill every slot: tombstones first while empty slots still end the chains
        gap_pct = 35;
        stall_pct = 35;
        write_limit(11'd2047);
        for (int pass = 0; pass < 2; pass++)
            for (int h = 0; h < CAPACITY; h++)
                if ((pass == 0 && tbl_used[h] && !tbl_live[h]) || (pass == 1 && !tbl_used[h]))
                    send_op(KIND_INSERT, fresh_key(h), $urandom, 1'b0, '0);

        // full table: misses scan every slot
        send_op(KIND_INSERT, fresh_key($urandom_range(CAPACITY - 1)), $urandom, 1'b0, '0);
        send_op(KIND_LOOKUP, fresh_key($urandom_range(CAPACITY - 1)), $urandom, 1'b0, '0);
        send_op(KIND_REMOVE, fresh_key($urandom_range(CAPACITY - 1)), $urandom, 1'b0, '0);
        send_op(KIND_SPARE, tbl_key[$urandom_range(CAPACITY - 1)], $urandom, 1'b0, '0);
        send_op(KIND_INSERT, tbl_key[$urandom_range(CAPACITY - 1)], $urandom, 1'b0, '0);
        slot = $urandom_range(CAPACITY - 1);
        send_op(KIND_REMOVE, tbl_key[slot], $urandom, 1'b0, '0);
        send_op(KIND_INSERT, fresh_key($urandom_range(CAPACITY - 1)), $urandom, 1'b0, '0);
        write_limit(11'd1024);
        send_op(KIND_INSERT, fresh_key($urandom_range(CAPACITY - 1)), $urandom, 1'b0, '0);
        slot = $urandom_range(CAPACITY - 1);
        key = tbl_key[slot];
        send_op(KIND_REMOVE, key, $urandom, 1'b0, '0);
        send_op(KIND_LOOKUP, key, $urandom, 1'b0, '0);

        drain_results();
        repeat (50) @(posedge clk);

        $display("Ran %0d operations, %0d results checked, under %0d limit settings,",
                 items_sent, results_checked, limit_writes);
        $display("from an empty table through tombstone chains to a completely full one.");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
rtl/lph_pkg.sv
rtl/lph_ram.sv
rtl/linear_probe_hash_map_unit.sv
tb/linear_probe_hash_map_unit_tb.sv
